[hw/rtl/pps_pkg.sv]
// Shared types and codes for the preemptive priority scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

    localparam int IDX_W = 8;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  slot;
        logic [15:0] arrival_time;
        logic [15:0] burst_length;
        logic [7:0]  priority_req;
    } cmd_t;

    typedef struct packed {
        logic        idle;
        logic [3:0]  run_slot;
        logic        finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [31:0] response;
        logic        all_done;
    } result_t;

    // Best candidate so far, handed from cell to cell during a scan.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [7:0]       prio;
        logic [15:0]      arrival;
        logic [15:0]      burst;
        logic [15:0]      remaining;
        logic             started;
        logic [31:0]      first_run;
        logic [1:0]       pending;
    } cand_t;

    localparam cand_t CAND_EMPTY = '{default: '0};

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic             load_en;
        logic             clear;
        logic             scan_en;
        logic [IDX_W-1:0] scan_idx;
        logic             apply_en;
        logic [IDX_W-1:0] win_idx;
    } cell_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/preemptive_priority_scheduler.sv]
// Top level: command sequencer, time counter and the chain of slot cells.
`timescale 1ns / 1ps
`default_nettype none
// Load and clear commands complete in the cycle they are taken and give no
// result. A tick command holds busy while the candidate walks the cell chain
// one slot per cycle, a calculation state updates the winning slot and the
// time, and a write-back state forms the result. The result appears with done for
// one cycle as busy drops and must be taken then; the receiver cannot stall.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pps_pkg::cmd_t    cmd,
    output logic                  done,
    output pps_pkg::result_t      result
);

    localparam int CW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam logic [CW-1:0] LAST = CW'(MAX_PROCS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_CALC = 4'b0100,
        S_WB   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   now_reg, now_inc;
    logic          accept;
    pps_pkg::cell_ctl_t ctl;
    pps_pkg::cand_t chain [MAX_PROCS+1];
    pps_pkg::cand_t win;

    logic        found_reg, fin_reg, alld_reg, done_reg;
    logic [3:0]  slot_reg;
    logic [15:0] burst_reg;
    logic [31:0] ta_reg, rt_reg;
    logic [31:0] ta_c, fr_c, arr32;
    pps_pkg::result_t result_reg;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign win    = chain[MAX_PROCS];
    assign now_inc = (now_reg == 32'hFFFF_FFFF) ? now_reg : now_reg + 32'd1;

    always_comb
    begin
        ctl.load_en  = accept && (cmd.opcode == pps_pkg::OP_LOAD);
        ctl.clear    = accept && (cmd.opcode == pps_pkg::OP_CLEAR);
        ctl.scan_en  = (state_reg == S_SCAN);
        ctl.scan_idx = pps_pkg::IDX_W'(cnt_reg);
        ctl.apply_en = (state_reg == S_CALC) && win.found;
        ctl.win_idx  = win.idx;
    end

    assign chain[0] = pps_pkg::CAND_EMPTY;

    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_cell
        pps_cell #(.IDX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .cmd      (cmd),
            .now      (now_reg),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept && cmd.opcode == pps_pkg::OP_TICK) state_next = S_SCAN;
            S_SCAN: if (cnt_reg == LAST) state_next = S_CALC;
            S_CALC: state_next = S_WB;
            S_WB:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            now_reg   <= 32'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_WB);
            if (state_reg == S_SCAN)
            begin
                cnt_reg <= (cnt_reg == LAST) ? '0 : cnt_reg + CW'(1);
            end
            if (ctl.clear)
            begin
                now_reg <= 32'd0;
            end
            else if (state_reg == S_CALC)
            begin
                now_reg <= now_inc;
            end
        end
    end

    assign arr32 = {16'd0, win.arrival};
    assign fr_c  = win.started ? win.first_run : now_reg;
    assign ta_c  = (now_inc > arr32) ? now_inc - arr32 : {16'd0, win.burst};

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CALC)
        begin
            found_reg <= win.found;
            fin_reg   <= win.found && (win.remaining == 16'd1);
            slot_reg  <= win.found ? win.idx[3:0] : 4'd0;
            burst_reg <= win.burst;
            ta_reg    <= ta_c;
            rt_reg    <= (fr_c > arr32) ? fr_c - arr32 : 32'd0;
            // after this tick: nothing pending, or only the winner and it finishes
            if (win.found && win.remaining == 16'd1)
            begin
                alld_reg <= (win.pending == 2'd1);
            end
            else
            begin
                alld_reg <= (win.pending == 2'd0);
            end
        end
        if (state_reg == S_WB)
        begin
            result_reg.idle       <= !found_reg;
            result_reg.run_slot   <= slot_reg;
            result_reg.finished   <= fin_reg;
            result_reg.turnaround <= fin_reg ? ta_reg : 32'd0;
            result_reg.waiting    <= (fin_reg && ta_reg > {16'd0, burst_reg})
                                     ? ta_reg - {16'd0, burst_reg} : 32'd0;
            result_reg.response   <= fin_reg ? rt_reg : 32'd0;
            result_reg.all_done   <= alld_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");
    a_idle_not_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.idle && result.finished))
        else $error("idle tick reported a completion");
    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> (now_reg == $past(now_reg)) || $past(ctl.clear))
        else $error("time moved during scan");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

endmodule
`default_nettype wire

[hw/rtl/pps_cell.sv]
// One process slot: holds its state and compares itself against the passing candidate.
`timescale 1ns / 1ps
`default_nettype none
module pps_cell #(
    parameter int IDX = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pps_pkg::cell_ctl_t ctl,
    input  wire pps_pkg::cmd_t      cmd,
    input  wire logic [31:0]        now,
    input  wire pps_pkg::cand_t     cand_in,
    output pps_pkg::cand_t          cand_out
);

    localparam logic [pps_pkg::IDX_W-1:0] MY_IDX = pps_pkg::IDX_W'(IDX);

    logic        valid_reg, done_reg, started_reg;
    logic [15:0] arrival_reg, burst_reg, remaining_reg;
    logic [7:0]  prio_reg;
    logic [31:0] first_run_reg;
    pps_pkg::cand_t cand_reg, cand_next;

    logic sel_load, sel_scan, sel_apply, pending, ready, better;

    assign sel_load  = ctl.load_en && ({4'd0, cmd.slot} == MY_IDX);
    assign sel_scan  = ctl.scan_en && (ctl.scan_idx == MY_IDX);
    assign sel_apply = ctl.apply_en && (ctl.win_idx == MY_IDX);
    assign pending   = valid_reg && !done_reg;
    assign ready     = pending && ({16'd0, arrival_reg} <= now);
    assign better    = !cand_in.found || (prio_reg < cand_in.prio) ||
                       ((prio_reg == cand_in.prio) && (arrival_reg < cand_in.arrival));

    always_comb
    begin
        cand_next = cand_in;
        if (ready && better)
        begin
            cand_next.found     = 1'b1;
            cand_next.idx       = MY_IDX;
            cand_next.prio      = prio_reg;
            cand_next.arrival   = arrival_reg;
            cand_next.burst     = burst_reg;
            cand_next.remaining = remaining_reg;
            cand_next.started   = started_reg;
            cand_next.first_run = first_run_reg;
        end
        // saturate at two: enough to tell whether anything else remains
        if (pending && cand_in.pending != 2'd2)
        begin
            cand_next.pending = cand_in.pending + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            done_reg    <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            valid_reg   <= 1'b0;
            done_reg    <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (sel_load)
        begin
            valid_reg   <= 1'b1;
            started_reg <= 1'b0;
            done_reg    <= (cmd.burst_length == 16'd0);
        end
        else if (sel_apply)
        begin
            started_reg <= 1'b1;
            done_reg    <= (remaining_reg == 16'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_load)
        begin
            arrival_reg   <= cmd.arrival_time;
            burst_reg     <= cmd.burst_length;
            remaining_reg <= cmd.burst_length;
            prio_reg      <= cmd.priority_req;
            first_run_reg <= 32'd0;
        end
        else if (sel_apply)
        begin
            remaining_reg <= remaining_reg - 16'd1;
            if (!started_reg)
            begin
                first_run_reg <= now;
            end
        end
        if (sel_scan)
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand_out = cand_reg;

endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the preemptive priority scheduler: directed table, then random commands.
`timescale 1ns / 1ps
module tb;

    localparam int NSLOT = 16;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] OP_BAD = 2'd3;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    pps_pkg::cmd_t cmd;
    logic done;
    pps_pkg::result_t result;

    preemptive_priority_scheduler #(.MAX_PROCS(NSLOT)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .done(done), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Scheduler copy kept in the testbench.
    logic [31:0] sched_time;
    logic        sv_valid [NSLOT];
    logic        sv_done [NSLOT];
    logic        sv_started [NSLOT];
    logic [15:0] sv_arrival [NSLOT];
    logic [15:0] sv_burst [NSLOT];
    logic [15:0] sv_remaining [NSLOT];
    logic [7:0]  sv_prio [NSLOT];
    logic [31:0] sv_first [NSLOT];

    pps_pkg::result_t tick_results [$];
    int errors;
    int stall_cycles;

    task automatic clear_sched();
        sched_time = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            sv_valid[i] = 1'b0;
            sv_done[i] = 1'b0;
            sv_started[i] = 1'b0;
        end
    endtask

    function automatic bit table_finished();
        for (int i = 0; i < NSLOT; i++)
            if (sv_valid[i] && !sv_done[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic schedule_cmd(input pps_pkg::cmd_t c);
        pps_pkg::result_t r;
        int best;
        int s;
        logic [31:0] arr;
        logic [31:0] ta;
        best = -1;
        r = '0;
        if (c.opcode == pps_pkg::OP_LOAD)
        begin
            s = c.slot;
            sv_valid[s] = 1'b1;
            sv_started[s] = 1'b0;
            sv_arrival[s] = c.arrival_time;
            sv_burst[s] = c.burst_length;
            sv_remaining[s] = c.burst_length;
            sv_prio[s] = c.priority_req;
            sv_first[s] = '0;
            sv_done[s] = (c.burst_length == 0);
        end
        else if (c.opcode == pps_pkg::OP_CLEAR)
            clear_sched();
        else if (c.opcode == pps_pkg::OP_TICK)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!sv_valid[i] || sv_done[i] || 32'(sv_arrival[i]) > sched_time)
                    continue;
                if (best < 0 || sv_prio[i] < sv_prio[best] ||
                    (sv_prio[i] == sv_prio[best] && sv_arrival[i] < sv_arrival[best]))
                    best = i;
            end
            if (best < 0)
            begin
                r.idle = 1'b1;
                if (sched_time != '1)
                    sched_time++;
            end
            else
            begin
                if (!sv_started[best])
                begin
                    sv_started[best] = 1'b1;
                    sv_first[best] = sched_time;
                end
                if (sched_time != '1)
                    sched_time++;
                sv_remaining[best] = sv_remaining[best] - 16'd1;
                r.run_slot = best[3:0];
                if (sv_remaining[best] == 0)
                begin
                    arr = 32'(sv_arrival[best]);
                    ta = sched_time > arr ? sched_time - arr : 32'(sv_burst[best]);
                    sv_done[best] = 1'b1;
                    r.finished = 1'b1;
                    r.turnaround = ta;
                    r.waiting = ta > 32'(sv_burst[best]) ? ta - 32'(sv_burst[best]) : '0;
                    r.response = sv_first[best] > arr ? sv_first[best] - arr : '0;
                end
            end
            r.all_done = table_finished();
            tick_results = {tick_results, r};
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (done)
            begin
                if (tick_results.size() == 0)
                begin
                    $error("unexpected result %p", result);
                    errors++;
                end
                else
                begin : cmp
                    pps_pkg::result_t e;
                    e = tick_results.pop_front();
                    if (result.idle !== e.idle)
                    begin
                        $error("idle: expected %0d actual %0d", e.idle, result.idle);
                        errors++;
                    end
                    if (result.run_slot !== e.run_slot)
                    begin
                        $error("run_slot: expected %0d actual %0d", e.run_slot,
                               result.run_slot);
                        errors++;
                    end
                    if (result.finished !== e.finished)
                    begin
                        $error("finished: expected %0d actual %0d", e.finished,
                               result.finished);
                        errors++;
                    end
                    if (result.turnaround !== e.turnaround)
                    begin
                        $error("turnaround: expected %0d actual %0d", e.turnaround,
                               result.turnaround);
                        errors++;
                    end
                    if (result.waiting !== e.waiting)
                    begin
                        $error("waiting: expected %0d actual %0d", e.waiting,
                               result.waiting);
                        errors++;
                    end
                    if (result.response !== e.response)
                    begin
                        $error("response: expected %0d actual %0d", e.response,
                               result.response);
                        errors++;
                    end
                    if (result.all_done !== e.all_done)
                    begin
                        $error("all_done: expected %0d actual %0d", e.all_done,
                               result.all_done);
                        errors++;
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Issue one command and hold start until the transfer.
    task automatic issue(input pps_pkg::cmd_t c);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        schedule_cmd(c);
    endtask

    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic pps_pkg::cmd_t make_cmd(input logic [1:0] op, input int s,
                                               input int a, input int b, input int p);
        pps_pkg::cmd_t c;
        c.opcode = op;
        c.slot = s[3:0];
        c.arrival_time = a[15:0];
        c.burst_length = b[15:0];
        c.priority_req = p[7:0];
        return c;
    endfunction

    function automatic pps_pkg::cmd_t rand_cmd();
        int k;
        k = $urandom_range(0, 99);
        if (k < 30)
        begin
            // Mostly small arrivals and bursts so slots finish; sometimes extremes.
            if ($urandom_range(0, 19) == 0)
                return make_cmd(pps_pkg::OP_LOAD, $urandom_range(0, 15),
                                $urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 255));
            return make_cmd(pps_pkg::OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 40),
                            $urandom_range(0, 8), $urandom_range(0, 255));
        end
        if (k < 96)
            return make_cmd(pps_pkg::OP_TICK, $urandom_range(0, 15), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 255));
        if (k < 98)
            return make_cmd(pps_pkg::OP_CLEAR, $urandom_range(0, 15),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 255));
        return make_cmd(OP_BAD, $urandom_range(0, 15), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 255));
    endfunction

    typedef struct {
        pps_pkg::cmd_t    c;
        bit               fixed;
        pps_pkg::result_t r;
    } step_t;

    step_t steps [$];

    task automatic add_step(input pps_pkg::cmd_t c, input bit fixed,
                            input pps_pkg::result_t r);
        step_t st;
        st.c = c;
        st.fixed = fixed;
        st.r = r;
        steps = {steps, st};
    endtask

    initial
    begin
        pps_pkg::result_t idle_empty;
        pps_pkg::result_t none;
        pps_pkg::cmd_t tick;
        errors = 0;
        stall_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        clear_sched();
        none = '0;
        idle_empty = '0;
        idle_empty.idle = 1'b1;
        idle_empty.all_done = 1'b1;
        tick = make_cmd(pps_pkg::OP_TICK, 0, 0, 0, 0);

        add_step(tick, 1'b1, idle_empty);
        add_step(make_cmd(OP_BAD, 15, 65535, 65535, 255), 1'b0, none);
        add_step(make_cmd(pps_pkg::OP_LOAD, 3, 0, 0, 0), 1'b0, none);
        add_step(tick, 1'b1, idle_empty);
        add_step(make_cmd(pps_pkg::OP_LOAD, 0, 1, 2, 255), 1'b0, none);
        add_step(make_cmd(pps_pkg::OP_LOAD, 15, 1, 2, 255), 1'b0, none);
        add_step(make_cmd(pps_pkg::OP_LOAD, 7, 0, 3, 0), 1'b0, none);
        add_step(make_cmd(pps_pkg::OP_LOAD, 9, 65535, 65535, 0), 1'b0, none);
        for (int i = 0; i < 8; i++)
            add_step(tick, 1'b0, none);
        add_step(make_cmd(pps_pkg::OP_LOAD, 7, 2, 1, 0), 1'b0, none);
        add_step(tick, 1'b0, none);
        add_step(tick, 1'b0, none);
        add_step(make_cmd(pps_pkg::OP_CLEAR, 0, 0, 0, 0), 1'b0, none);
        add_step(tick, 1'b1, idle_empty);
        add_step(make_cmd(pps_pkg::OP_LOAD, 5, 0, 1, 10), 1'b0, none);
        add_step(tick, 1'b0, none);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            issue(steps[i].c);
            if (steps[i].fixed)
                tick_results[$] = steps[i].r;
            pause_random();
        end

        for (int n = 0; n < 1700; n++)
        begin
            if (n == 800)
            begin
                start <= 1'b0;
                while (tick_results.size() != 0)
                    @(posedge clk);
            end
            issue(rand_cmd());
            pause_random();
        end
        start <= 1'b0;

        while (tick_results.size() != 0)
            @(posedge clk);
        repeat (2 * NSLOT + 8) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
